@@ src/time_of_day_text_parser_assert.svh @@
// ----------------------------------------------------------------------------
// time_of_day_text_parser assertion macros
// shared assertion forms for the parser checks, clocked on clk
// ----------------------------------------------------------------------------
`ifndef TIME_OF_DAY_TEXT_PARSER_ASSERT_SVH
`define TIME_OF_DAY_TEXT_PARSER_ASSERT_SVH

// same-cycle implication, off during reset
`define TDP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tdp check failed");

// next-cycle implication, off during reset
`define TDP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tdp check failed");

// next-cycle implication that also runs through reset
`define TDP_ASSERT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("tdp check failed");

`endif

@@ src/tdp_pkg.sv @@
// ----------------------------------------------------------------------------
// tdp_pkg
// types, constants and the per-character step function of the time parser
// ----------------------------------------------------------------------------
package tdp_pkg;

  localparam int MAX_TEXT_LEN = 255;
  localparam int POS_W        = $clog2(MAX_TEXT_LEN + 1);
  localparam int LEN_W        = 8;
  localparam int LEN_MAX      = 255;
  // passes of the step function per character: the worst case number of phase changes one character can cause, plus one
  localparam int FEED_STEPS   = 4;

  localparam logic [7:0] HOUR_LIMIT = 8'd24;
  localparam logic [7:0] MIN_LIMIT  = 8'd60;
  localparam logic [4:0] HOUR_NOON  = 5'd12;
  localparam logic [4:0] HOUR_PM    = 5'd12;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_M  = 8'h4D;
  localparam logic [7:0] CH_UP_P  = 8'h50;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_M  = 8'h6D;
  localparam logic [7:0] CH_LO_P  = 8'h70;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;

  typedef enum logic [15:0] {
    PH_H_WS     = 16'b0000_0000_0000_0001,
    PH_H_SIGN   = 16'b0000_0000_0000_0010,
    PH_H_DIG    = 16'b0000_0000_0000_0100,
    PH_M_WS     = 16'b0000_0000_0000_1000,
    PH_M_SIGN   = 16'b0000_0000_0001_0000,
    PH_M_DIG    = 16'b0000_0000_0010_0000,
    PH_S_WS     = 16'b0000_0000_0100_0000,
    PH_S_SIGN   = 16'b0000_0000_1000_0000,
    PH_S_DIG    = 16'b0000_0001_0000_0000,
    PH_AFTER_H  = 16'b0000_0010_0000_0000,
    PH_AFTER_M  = 16'b0000_0100_0000_0000,
    PH_AP_WS    = 16'b0000_1000_0000_0000,
    PH_AP_LET   = 16'b0001_0000_0000_0000,
    PH_AP_M     = 16'b0010_0000_0000_0000,
    PH_AP_TRAIL = 16'b0100_0000_0000_0000,
    PH_FINISH   = 16'b1000_0000_0000_0000
  } phase_t;

  typedef enum logic [1:0] {
    MER_NONE = 2'd0,
    MER_AM   = 2'd1,
    MER_PM   = 2'd2
  } mer_t;

  typedef struct packed {
    phase_t           phase;
    logic [7:0]       accum;
    logic             neg;
    logic [4:0]       hour;
    logic [5:0]       minute;
    logic [5:0]       second;
    mer_t             mer;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] clen;
    logic             ok;
  } pstate_t;

  typedef struct packed {
    pstate_t st;
    logic    used;
  } step_t;

  localparam pstate_t PST_RESET = '{
    phase:  PH_H_WS,
    accum:  8'd0,
    neg:    1'b0,
    hour:   5'd0,
    minute: 6'd0,
    second: 6'd0,
    mer:    MER_NONE,
    pos:    '0,
    clen:   '0,
    ok:     1'b0
  };

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || (c inside {[CH_TAB:CH_CR]});
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[CH_ZERO:CH_NINE]};
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c inside {[CH_UP_A:CH_UP_Z]}) || (c inside {[CH_LO_A:CH_LO_Z]});
  endfunction

  function automatic pstate_t finish_st(input pstate_t s, input logic ok,
                                        input logic [POS_W-1:0] len);
    pstate_t r;
    r = s;
    r.ok = ok;
    r.clen = len;
    r.phase = PH_FINISH;
    return r;
  endfunction

  function automatic pstate_t start_mer(input pstate_t s, input logic ok);
    pstate_t r;
    r = s;
    r.clen = s.pos;
    r.ok = ok;
    r.mer = MER_NONE;
    r.phase = PH_AP_WS;
    return r;
  endfunction

  function automatic pstate_t mer_fallback(input pstate_t s);
    pstate_t r;
    r = s;
    r.mer = MER_NONE;
    return finish_st(r, s.ok, s.clen);
  endfunction

  // one pass of the phase machine; used is low when the character must be
  // looked at again in the new phase
  function automatic step_t tdp_step(input pstate_t s, input logic [7:0] c);
    step_t            r;
    logic [POS_W-1:0] pos_adv;
    logic [7:0]       digit;
    logic [11:0]      prod;
    logic [7:0]       acc_sat;
    logic [7:0]       limit;
    logic             num_ok;
    logic             ampm;
    phase_t           dig_ph;
    phase_t           sign_ph;
    r.st = s;
    r.used = 1'b0;
    pos_adv = (s.pos < POS_W'(MAX_TEXT_LEN)) ? s.pos + POS_W'(1) : s.pos;
    digit = c - CH_ZERO;
    prod = ({4'd0, s.accum} << 3) + ({4'd0, s.accum} << 1) + {4'd0, digit};
    acc_sat = (prod > 12'd255) ? 8'hFF : prod[7:0];
    ampm = (s.hour >= 5'd1) && (s.hour <= HOUR_NOON);
    if (s.phase inside {PH_H_WS, PH_H_SIGN, PH_H_DIG}) begin
      dig_ph = PH_H_DIG;
      sign_ph = PH_H_SIGN;
      limit = HOUR_LIMIT;
    end else if (s.phase inside {PH_M_WS, PH_M_SIGN, PH_M_DIG}) begin
      dig_ph = PH_M_DIG;
      sign_ph = PH_M_SIGN;
      limit = MIN_LIMIT;
    end else begin
      dig_ph = PH_S_DIG;
      sign_ph = PH_S_SIGN;
      limit = MIN_LIMIT;
    end
    // minus zero passes, any other negative value fails
    num_ok = (!s.neg || (s.accum == 8'd0)) && (s.accum < limit);

    case (s.phase)
      PH_H_WS, PH_M_WS, PH_S_WS: begin
        if (is_digit(c)) begin
          r.st.accum = digit;
          r.st.phase = dig_ph;
          r.st.pos = pos_adv;
          r.used = 1'b1;
        end else if (is_ws(c)) begin
          r.st.pos = pos_adv;
          r.used = 1'b1;
        end else if ((c == CH_PLUS) || (c == CH_MINUS)) begin
          r.st.neg = (c == CH_MINUS);
          r.st.phase = sign_ph;
          r.st.pos = pos_adv;
          r.used = 1'b1;
        end else begin
          r.st = finish_st(s, 1'b0, '0);
        end
      end
      PH_H_SIGN, PH_M_SIGN, PH_S_SIGN: begin
        if (is_digit(c)) begin
          r.st.accum = digit;
          r.st.phase = dig_ph;
          r.st.pos = pos_adv;
          r.used = 1'b1;
        end else begin
          r.st = finish_st(s, 1'b0, '0);
        end
      end
      PH_H_DIG, PH_M_DIG, PH_S_DIG: begin
        if (is_digit(c)) begin
          r.st.accum = acc_sat;
          r.st.pos = pos_adv;
          r.used = 1'b1;
        end else begin
          r.st.accum = 8'd0;
          r.st.neg = 1'b0;
          if (!num_ok) begin
            r.st = finish_st(r.st, 1'b0, '0);
          end else if (s.phase == PH_H_DIG) begin
            r.st.hour = s.accum[4:0];
            r.st.phase = PH_AFTER_H;
          end else if (s.phase == PH_M_DIG) begin
            r.st.minute = s.accum[5:0];
            r.st.phase = PH_AFTER_M;
          end else begin
            r.st.second = s.accum[5:0];
            if (ampm) begin
              r.st = start_mer(r.st, 1'b1);
            end else begin
              r.st = finish_st(r.st, 1'b1, s.pos);
            end
          end
        end
      end
      PH_AFTER_H: begin
        if (is_ws(c)) begin
          r.st.pos = pos_adv;
          r.used = 1'b1;
        end else if (c == CH_COLON) begin
          r.st.pos = pos_adv;
          r.st.phase = PH_M_WS;
          r.used = 1'b1;
        end else if (ampm) begin
          // bare hour stands only with a suffix
          r.st = start_mer(s, 1'b0);
        end else begin
          r.st = finish_st(s, 1'b0, '0);
        end
      end
      PH_AFTER_M: begin
        if (is_ws(c)) begin
          r.st.pos = pos_adv;
          r.used = 1'b1;
        end else if (c == CH_COLON) begin
          r.st.pos = pos_adv;
          r.st.phase = PH_S_WS;
          r.used = 1'b1;
        end else if (ampm) begin
          r.st = start_mer(s, 1'b1);
        end else begin
          r.st = finish_st(s, 1'b1, s.pos);
        end
      end
      PH_AP_WS: begin
        if (is_ws(c)) begin
          r.st.pos = pos_adv;
          r.used = 1'b1;
        end else if ((c == CH_UP_A) || (c == CH_LO_A) || (c == CH_UP_P) || (c == CH_LO_P)) begin
          r.st.mer = ((c == CH_UP_A) || (c == CH_LO_A)) ? MER_AM : MER_PM;
          r.st.pos = pos_adv;
          r.st.phase = PH_AP_LET;
          r.used = 1'b1;
        end else begin
          r.st = mer_fallback(s);
        end
      end
      PH_AP_LET: begin
        if (c == CH_NUL) begin
          r.st = finish_st(s, 1'b1, s.pos);
        end else if ((c == CH_UP_M) || (c == CH_LO_M)) begin
          r.st.pos = pos_adv;
          r.st.phase = PH_AP_M;
          r.used = 1'b1;
        end else begin
          r.st = mer_fallback(s);
        end
      end
      PH_AP_M: begin
        if (is_alpha(c)) begin
          r.st = mer_fallback(s);
        end else if (is_ws(c)) begin
          r.st.pos = pos_adv;
          r.st.phase = PH_AP_TRAIL;
          r.used = 1'b1;
        end else begin
          r.st = finish_st(s, 1'b1, s.pos);
        end
      end
      PH_AP_TRAIL: begin
        if (is_ws(c)) begin
          r.st.pos = pos_adv;
          r.used = 1'b1;
        end else begin
          r.st = finish_st(s, 1'b1, s.pos);
        end
      end
      PH_FINISH: begin
        r.used = 1'b1;
      end
      default: begin
        r.used = 1'b1;
      end
    endcase
    return r;
  endfunction

  // run the phase machine until the character is used up
  function automatic pstate_t tdp_feed(input pstate_t s, input logic [7:0] c);
    pstate_t cur;
    step_t   t;
    logic    done;
    cur = s;
    done = 1'b0;
    for (int i = 0; i < FEED_STEPS; i++) begin
      t = tdp_step(cur, c);
      if (!done) begin
        cur = t.st;
        done = t.used;
      end
    end
    return cur;
  endfunction

endpackage

@@ src/time_of_day_text_parser.sv @@
// ----------------------------------------------------------------------------
// time_of_day_text_parser
// takes one character per cycle unless stalled; results pass snapshot and output regs
// throughput is one character per cycle, set by the single parse-state register loop
// synchronous active-low reset returns the parser to the start of a text, drops results
// ----------------------------------------------------------------------------
module time_of_day_text_parser (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_character,
  input  logic       in_end_of_text,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_valid_res,
  output logic [4:0] out_hour,
  output logic [5:0] out_minute,
  output logic [5:0] out_second,
  output logic [7:0] out_used_length
);

  logic             snap_valid;
  logic             snap_ready;
  tdp_pkg::pstate_t snap_state;

  tdp_parse u_parse (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_character   (in_character),
    .in_end_of_text (in_end_of_text),
    .snap_valid     (snap_valid),
    .snap_state     (snap_state),
    .snap_ready     (snap_ready)
  );

  tdp_finish u_finish (
    .clk             (clk),
    .rst_n           (rst_n),
    .snap_valid      (snap_valid),
    .snap_state      (snap_state),
    .snap_ready      (snap_ready),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_valid_res   (out_valid_res),
    .out_hour        (out_hour),
    .out_minute      (out_minute),
    .out_second      (out_second),
    .out_used_length (out_used_length)
  );

endmodule

@@ src/tdp_parse.sv @@
// ----------------------------------------------------------------------------
// tdp_parse
// input stage: per-character parse state and the end-of-text snapshot register
// ----------------------------------------------------------------------------
module tdp_parse (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_character,
  input  logic             in_end_of_text,
  output logic             snap_valid,
  output tdp_pkg::pstate_t snap_state,
  input  logic             snap_ready
);

  tdp_pkg::pstate_t state_r;
  tdp_pkg::pstate_t state_nxt;
  tdp_pkg::pstate_t fed;
  tdp_pkg::pstate_t snap_state_r;
  tdp_pkg::pstate_t snap_state_nxt;
  logic             snap_valid_r;
  logic             snap_valid_nxt;
  logic             accept;
  logic             term;

  assign in_stall = snap_valid_r && !snap_ready;
  assign accept   = in_valid && !in_stall;
  // a nul ends the text by itself and is not fed
  assign term     = (in_character == tdp_pkg::CH_NUL) || in_end_of_text;

  always_comb begin
    fed = (in_character != tdp_pkg::CH_NUL) ? tdp_pkg::tdp_feed(state_r, in_character)
                                            : state_r;
    state_nxt = state_r;
    snap_state_nxt = snap_state_r;
    snap_valid_nxt = snap_valid_r && !snap_ready;
    if (accept) begin
      if (term) begin
        state_nxt = tdp_pkg::PST_RESET;
        snap_state_nxt = fed;
        snap_valid_nxt = 1'b1;
      end else begin
        state_nxt = fed;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tdp_pkg::PST_RESET;
      snap_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      snap_valid_r <= snap_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    snap_state_r <= snap_state_nxt;
  end

  assign snap_valid = snap_valid_r;
  assign snap_state = snap_state_r;

endmodule

@@ src/tdp_finish.sv @@
// ----------------------------------------------------------------------------
// tdp_finish
// closes the text with an end character, applies am/pm and holds the result
// ----------------------------------------------------------------------------
module tdp_finish (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             snap_valid,
  input  tdp_pkg::pstate_t snap_state,
  output logic             snap_ready,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_valid_res,
  output logic [4:0]       out_hour,
  output logic [5:0]       out_minute,
  output logic [5:0]       out_second,
  output logic [7:0]       out_used_length
);

  tdp_pkg::pstate_t fed;
  logic             take;
  logic [4:0]       hour_adj;
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic             valid_res_r;
  logic             valid_res_nxt;
  logic [4:0]       hour_r;
  logic [4:0]       hour_nxt;
  logic [5:0]       minute_r;
  logic [5:0]       minute_nxt;
  logic [5:0]       second_r;
  logic [5:0]       second_nxt;
  logic [7:0]       len_r;
  logic [7:0]       len_nxt;

  assign snap_ready = !out_valid_r || !out_stall;
  assign take       = snap_valid && snap_ready;

  always_comb begin
    fed = tdp_pkg::tdp_feed(snap_state, tdp_pkg::CH_NUL);
    hour_adj = fed.hour;
    if (fed.hour == tdp_pkg::HOUR_NOON) begin
      if (fed.mer == tdp_pkg::MER_AM) begin
        hour_adj = 5'd0;
      end
    end else if (fed.mer == tdp_pkg::MER_PM) begin
      hour_adj = fed.hour + tdp_pkg::HOUR_PM;
    end

    out_valid_nxt = take || (out_valid_r && out_stall);
    valid_res_nxt = valid_res_r;
    hour_nxt = hour_r;
    minute_nxt = minute_r;
    second_nxt = second_r;
    len_nxt = len_r;
    if (take) begin
      // a rejected text reports all fields as zero
      valid_res_nxt = fed.ok;
      hour_nxt = fed.ok ? hour_adj : 5'd0;
      minute_nxt = fed.ok ? fed.minute : 6'd0;
      second_nxt = fed.ok ? fed.second : 6'd0;
      if (!fed.ok) begin
        len_nxt = 8'd0;
      end else if (int'(fed.clen) > tdp_pkg::LEN_MAX) begin
        len_nxt = tdp_pkg::LEN_W'(tdp_pkg::LEN_MAX);
      end else begin
        len_nxt = tdp_pkg::LEN_W'(fed.clen);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    valid_res_r <= valid_res_nxt;
    hour_r <= hour_nxt;
    minute_r <= minute_nxt;
    second_r <= second_nxt;
    len_r <= len_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_valid_res   = valid_res_r;
  assign out_hour        = hour_r;
  assign out_minute      = minute_r;
  assign out_second      = second_r;
  assign out_used_length = len_r;

endmodule

@@ src/tdp_checker.sv @@
// ----------------------------------------------------------------------------
// tdp_checker
// port-level checks on the time parser, bound to the top level
// ----------------------------------------------------------------------------
`include "time_of_day_text_parser_assert.svh"

module tdp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] in_character,
  input logic       in_end_of_text,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_valid_res,
  input logic [4:0] out_hour,
  input logic [5:0] out_minute,
  input logic [5:0] out_second,
  input logic [7:0] out_used_length
);

  logic in_seen;
  logic rej_zero;
  logic in_range;

  // a transaction that closes a text
  assign in_seen  = in_valid && !in_stall
                    && (in_end_of_text || (in_character == tdp_pkg::CH_NUL));
  assign rej_zero = (out_hour == 5'd0) && (out_minute == 6'd0) && (out_second == 6'd0)
                    && (out_used_length == 8'd0);
  assign in_range = (out_hour < 5'd24) && (out_minute < 6'd60) && (out_second < 6'd60);

  `TDP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  `TDP_ASSERT_ALWAYS(a_reset_clears, !rst_n, !out_valid)
  `TDP_ASSERT_NOW(a_reject_zero, out_valid && !out_valid_res, rej_zero)
  `TDP_ASSERT_NOW(a_time_range, out_valid && out_valid_res, in_range)
  // with the result side idle, a closed text passes the snapshot register and then shows up
  `TDP_ASSERT_NEXT(a_end_fills, in_seen && !out_valid, ##1 out_valid)

endmodule

bind time_of_day_text_parser tdp_checker u_tdp_checker (.*);

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// time_of_day_text_parser testbench
// streams character texts into the parser and checks every time reading
// against a cycle-free model of the parse, with random gaps on both channels
// and long receiver hold-offs that back the parser up
// ----------------------------------------------------------------------------
module testbench;
  import tdp_pkg::*;

  typedef struct packed {
    logic [7:0] ch;
    logic       eot;
  } text_byte_t;

  typedef struct packed {
    logic       valid_res;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [7:0] used_length;
  } time_reading_t;

  logic       clk             = 1'b0;
  logic       rst_n           = 1'b0;
  logic       in_valid        = 1'b0;
  logic [7:0] in_character    = 8'd0;
  logic       in_end_of_text  = 1'b0;
  logic       out_stall       = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic       out_valid_res;
  logic [4:0] out_hour;
  logic [5:0] out_minute;
  logic [5:0] out_second;
  logic [7:0] out_used_length;

  text_byte_t    text_bytes[$];
  time_reading_t expected_times[$];
  text_byte_t    next_byte;

  int chars_sent   = 0;
  int results_seen = 0;
  int times_valid  = 0;
  int errors       = 0;
  int send_gap     = 0;
  int send_calm    = 0;
  int recv_pause   = 0;
  int recv_calm    = 0;
  int hold_left    = 0;
  int holds_done   = 0;

  // parse state of the model
  phase_t     cur_phase;
  logic [7:0] num_acc;
  logic       num_neg;
  logic [4:0] hour_v;
  logic [5:0] min_v;
  logic [5:0] sec_v;
  mer_t       mer_kind;
  logic [7:0] char_pos;
  logic [7:0] kept_len;
  logic       time_ok;

  time_of_day_text_parser i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_character   (in_character),
    .in_end_of_text (in_end_of_text),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_valid_res  (out_valid_res),
    .out_hour       (out_hour),
    .out_minute     (out_minute),
    .out_second     (out_second),
    .out_used_length(out_used_length)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------- model

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic is_numeral(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LO_A && c <= CH_LO_Z);
  endfunction

  function automatic void clear_parser();
    cur_phase = PH_H_WS;
    num_acc   = 8'd0;
    num_neg   = 1'b0;
    hour_v    = 5'd0;
    min_v     = 6'd0;
    sec_v     = 6'd0;
    mer_kind  = MER_NONE;
    char_pos  = 8'd0;
    kept_len  = 8'd0;
    time_ok   = 1'b0;
  endfunction

  function automatic void bump_pos();
    if (char_pos < 8'(MAX_TEXT_LEN)) char_pos = char_pos + 8'd1;
  endfunction

  function automatic logic meridiem_hour();
    return hour_v >= 5'd1 && hour_v <= HOUR_NOON;
  endfunction

  function automatic void settle(input logic ok, input logic [7:0] len);
    time_ok   = ok;
    kept_len  = len;
    cur_phase = PH_FINISH;
  endfunction

  // remember where a valid time ends in case the suffix does not hold
  function automatic void open_suffix(input logic ok);
    kept_len  = char_pos;
    time_ok   = ok;
    mer_kind  = MER_NONE;
    cur_phase = PH_AP_WS;
  endfunction

  function automatic void drop_suffix();
    mer_kind = MER_NONE;
    settle(time_ok, kept_len);
  endfunction

  function automatic void close_number(input int grp);
    logic [7:0] v;
    logic       pass;
    v = num_acc;
    pass = (!num_neg || v == 8'd0) && (v < ((grp == 0) ? HOUR_LIMIT : MIN_LIMIT));
    num_acc = 8'd0;
    num_neg = 1'b0;
    if (!pass) begin
      settle(1'b0, 8'd0);
    end else if (grp == 0) begin
      hour_v = v[4:0];
      cur_phase = PH_AFTER_H;
    end else if (grp == 1) begin
      min_v = v[5:0];
      cur_phase = PH_AFTER_M;
    end else begin
      sec_v = v[5:0];
      if (meridiem_hour()) open_suffix(1'b1);
      else settle(1'b1, char_pos);
    end
  endfunction

  // returns 1 once the character is used up, 0 when the new phase must see it again
  function automatic bit step_char(input logic [7:0] c);
    int     grp;
    int     total;
    logic   ok_flag;
    phase_t dig_ph;
    phase_t sign_ph;
    case (cur_phase)
      PH_AFTER_H, PH_AFTER_M: begin
        if (is_blank(c)) begin
          bump_pos();
          return 1'b1;
        end
        if (c == CH_COLON) begin
          bump_pos();
          cur_phase = (cur_phase == PH_AFTER_H) ? PH_M_WS : PH_S_WS;
          return 1'b1;
        end
        // a bare hour only counts with a suffix
        ok_flag = (cur_phase == PH_AFTER_M);
        if (meridiem_hour()) open_suffix(ok_flag);
        else settle(ok_flag, ok_flag ? char_pos : 8'd0);
        return 1'b0;
      end
      PH_AP_WS: begin
        if (is_blank(c)) begin
          bump_pos();
          return 1'b1;
        end
        if (c == CH_UP_A || c == CH_LO_A || c == CH_UP_P || c == CH_LO_P) begin
          mer_kind = (c == CH_UP_A || c == CH_LO_A) ? MER_AM : MER_PM;
          bump_pos();
          cur_phase = PH_AP_LET;
          return 1'b1;
        end
        drop_suffix();
        return 1'b0;
      end
      PH_AP_LET: begin
        if (c == CH_NUL) begin
          settle(1'b1, char_pos);
          return 1'b0;
        end
        if (c == CH_UP_M || c == CH_LO_M) begin
          bump_pos();
          cur_phase = PH_AP_M;
          return 1'b1;
        end
        drop_suffix();
        return 1'b0;
      end
      PH_AP_M: begin
        if (is_letter(c)) begin
          drop_suffix();
          return 1'b0;
        end
        if (is_blank(c)) begin
          bump_pos();
          cur_phase = PH_AP_TRAIL;
          return 1'b1;
        end
        settle(1'b1, char_pos);
        return 1'b0;
      end
      PH_AP_TRAIL: begin
        if (is_blank(c)) begin
          bump_pos();
          return 1'b1;
        end
        settle(1'b1, char_pos);
        return 1'b0;
      end
      PH_FINISH: begin
        return 1'b1;
      end
      default: begin
        if (cur_phase inside {PH_H_WS, PH_H_SIGN, PH_H_DIG}) begin
          grp = 0;
          dig_ph = PH_H_DIG;
          sign_ph = PH_H_SIGN;
        end else if (cur_phase inside {PH_M_WS, PH_M_SIGN, PH_M_DIG}) begin
          grp = 1;
          dig_ph = PH_M_DIG;
          sign_ph = PH_M_SIGN;
        end else begin
          grp = 2;
          dig_ph = PH_S_DIG;
          sign_ph = PH_S_SIGN;
        end
        if (is_numeral(c)) begin
          if (cur_phase == dig_ph) begin
            total = int'(num_acc) * 10 + int'(c) - int'(CH_ZERO);
            num_acc = (total > 255) ? 8'd255 : 8'(total);
          end else begin
            num_acc = c - CH_ZERO;
            cur_phase = dig_ph;
          end
          bump_pos();
          return 1'b1;
        end
        if (cur_phase == dig_ph) begin
          close_number(grp);
          return 1'b0;
        end
        if (cur_phase == sign_ph) begin
          settle(1'b0, 8'd0);
          return 1'b0;
        end
        if (is_blank(c)) begin
          bump_pos();
          return 1'b1;
        end
        if (c == CH_PLUS || c == CH_MINUS) begin
          num_neg = (c == CH_MINUS);
          cur_phase = sign_ph;
          bump_pos();
          return 1'b1;
        end
        settle(1'b0, 8'd0);
        return 1'b0;
      end
    endcase
  endfunction

  function automatic void feed_char(input logic [7:0] c);
    bit used;
    used = 1'b0;
    while (!used) used = step_char(c);
  endfunction

  // one accepted transaction; a text end queues the expected reading
  function automatic void take_input(input logic [7:0] c, input logic eot);
    time_reading_t r;
    if (c != CH_NUL) begin
      feed_char(c);
      if (!eot) return;
    end
    feed_char(CH_NUL);
    r = '0;
    if (time_ok) begin
      r.valid_res = 1'b1;
      r.hour = hour_v;
      if (hour_v == HOUR_NOON) begin
        if (mer_kind == MER_AM) r.hour = 5'd0;
      end else if (mer_kind == MER_PM) begin
        r.hour = hour_v + HOUR_PM;
      end
      r.minute = min_v;
      r.second = sec_v;
      r.used_length = kept_len;
    end
    expected_times.push_back(r);
    clear_parser();
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic int pick_pause(inout int calm_left);
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm_left = $urandom_range(20, 80);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void push_byte(input logic [7:0] c, input logic eot);
    text_byte_t b;
    b.ch = c;
    b.eot = eot;
    text_bytes.push_back(b);
  endfunction

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i], 1'b0);
  endfunction

  function automatic void mark_end();
    text_byte_t b;
    b = text_bytes.pop_back();
    b.eot = 1'b1;
    text_bytes.push_back(b);
  endfunction

  function automatic logic [7:0] blank_char();
    int r;
    r = $urandom_range(9, 14);
    return (r == 14) ? CH_SPACE : 8'(r);
  endfunction

  function automatic void push_blanks(input int most);
    int n;
    n = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, most);
    repeat (n) push_byte(blank_char(), 1'b0);
  endfunction

  function automatic void push_number(input int lim);
    int r;
    int v;
    r = $urandom_range(0, 99);
    if (r < 10) v = $urandom_range(0, 1) ? 12 : 0;
    else if (r < 82) v = $urandom_range(0, lim - 1);
    else if (r < 93) v = $urandom_range(lim, 99);
    else v = $urandom_range(100, 999);
    if ($urandom_range(0, 9) == 0) push_byte(CH_ZERO, 1'b0);
    push_text($sformatf("%0d", v));
  endfunction

  function automatic void push_sign();
    if ($urandom_range(0, 11) == 0) push_byte($urandom_range(0, 1) ? CH_MINUS : CH_PLUS, 1'b0);
  endfunction

  // the text ends on its last character or on a trailing NUL
  function automatic void end_text(input int start);
    if (text_bytes.size() > start && $urandom_range(0, 1)) mark_end();
    else push_byte(CH_NUL, 1'($urandom_range(0, 1)));
  endfunction

  function automatic void gen_time_text();
    string letters;
    int    start;
    int    form;
    letters = "AaPp";
    start = text_bytes.size();
    push_blanks(3);
    push_sign();
    push_number(24);
    form = $urandom_range(0, 2);
    if (form >= 1) begin
      push_blanks(2);
      push_byte(CH_COLON, 1'b0);
      push_blanks(2);
      push_sign();
      push_number(60);
    end
    if (form >= 2) begin
      push_blanks(2);
      push_byte(CH_COLON, 1'b0);
      push_blanks(2);
      push_sign();
      push_number(60);
    end
    if ($urandom_range(0, 2) != 0) begin
      push_blanks(2);
      push_byte(letters[$urandom_range(0, 3)], 1'b0);
      if ($urandom_range(0, 9) < 7) push_byte($urandom_range(0, 1) ? CH_UP_M : CH_LO_M, 1'b0);
      if ($urandom_range(0, 9) < 3) push_blanks(3);
    end
    if ($urandom_range(0, 6) == 0) push_byte(8'($urandom_range(1, 255)), 1'b0);
    end_text(start);
  endfunction

  function automatic void gen_noise();
    string letters;
    int    start;
    int    r;
    letters = "AaPpMmxZ";
    start = text_bytes.size();
    repeat ($urandom_range(0, 12)) begin
      r = $urandom_range(0, 99);
      if (r < 25) push_byte(8'($urandom_range(int'(CH_ZERO), int'(CH_NINE))), 1'b0);
      else if (r < 40) push_byte(CH_COLON, 1'b0);
      else if (r < 55) push_byte(blank_char(), 1'b0);
      else if (r < 70) push_byte(letters[$urandom_range(0, 7)], 1'b0);
      else if (r < 75) push_byte($urandom_range(0, 1) ? CH_MINUS : CH_PLUS, 1'b0);
      else push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 7) == 0));
    end
    end_text(start);
  endfunction

  function automatic void build_stimulus();
    int start;
    // field extremes, trailing tab, NUL that also carries the end mark
    push_text("23:59:59\t");
    push_byte(CH_NUL, 1'b1);
    // lone suffix letter at the end, noon as am
    push_text("12a");
    mark_end();
    // minus zero hour, saturating minute
    push_text("-0:999");
    mark_end();
    // suffix running into a letter after the minutes
    push_text("1:2pmz");
    push_byte(CH_NUL, 1'b0);
    // empty text
    push_byte(CH_NUL, 1'b1);
    // rejected hour, then bytes after the decision
    push_text("5x9");
    push_byte(8'hFF, 1'b1);

    while (text_bytes.size() < 1750) begin
      if (text_bytes.size() > 300 && text_bytes.size() < 320) begin
        // position counter saturation
        start = text_bytes.size();
        repeat (270) push_byte(blank_char(), 1'b0);
        push_text("7:30 pm");
        end_text(start);
      end else if (text_bytes.size() > 1100 && text_bytes.size() < 1120) begin
        start = text_bytes.size();
        repeat (260) push_byte(CH_ZERO, 1'b0);
        push_text(":5");
        end_text(start);
      end else if ($urandom_range(0, 3) != 0) begin
        gen_time_text();
      end else begin
        gen_noise();
      end
    end
  endfunction

  // ---------------------------------------------------------------- driver

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_character <= 8'd0;
      in_end_of_text <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        take_input(in_character, in_end_of_text);
        chars_sent <= chars_sent + 1;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (text_bytes.size() != 0) begin
          next_byte = text_bytes.pop_front();
          in_valid <= 1'b1;
          in_character <= next_byte.ch;
          in_end_of_text <= next_byte.eot;
          send_gap = pick_pause(send_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-offs while the sender keeps going
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      holds_done <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (holds_done < 2 && chars_sent >= 500 * (holds_done + 1)) begin
      hold_left <= 300;
      holds_done <= holds_done + 1;
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk) begin : monitor
    time_reading_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      recv_pause = 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (out_valid_res) times_valid++;
        if (expected_times.size() == 0) begin
          $error("unexpected result: valid_res %0d hour %0d minute %0d second %0d length %0d",
                 out_valid_res, out_hour, out_minute, out_second, out_used_length);
          errors++;
        end else begin
          want = expected_times.pop_front();
          if (out_valid_res !== want.valid_res) begin
            $error("valid_res: expected %0d, actual %0d", want.valid_res, out_valid_res);
            errors++;
          end
          if (out_hour !== want.hour) begin
            $error("hour: expected %0d, actual %0d", want.hour, out_hour);
            errors++;
          end
          if (out_minute !== want.minute) begin
            $error("minute: expected %0d, actual %0d", want.minute, out_minute);
            errors++;
          end
          if (out_second !== want.second) begin
            $error("second: expected %0d, actual %0d", want.second, out_second);
            errors++;
          end
          if (out_used_length !== want.used_length) begin
            $error("used_length: expected %0d, actual %0d", want.used_length, out_used_length);
            errors++;
          end
        end
      end
      if (recv_pause > 0) begin
        recv_pause--;
        out_stall <= 1'b1;
      end else if (hold_left != 0) begin
        out_stall <= 1'b1;
      end else begin
        recv_pause = pick_pause(recv_calm);
        out_stall <= (recv_pause != 0);
        if (recv_pause != 0) recv_pause--;
      end
    end
  end

  // ---------------------------------------------------------------- control

  initial begin
    clear_parser();
    build_stimulus();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    while (text_bytes.size() != 0 || in_valid) @(posedge clk);
    while (expected_times.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("sent %0d characters, got %0d readings (%0d valid times), %0d long hold-offs",
             chars_sent, results_seen, times_valid, holds_done);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("timeout with %0d readings outstanding", expected_times.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+src
src/tdp_pkg.sv
src/tdp_parse.sv
src/tdp_finish.sv
src/time_of_day_text_parser.sv
src/tdp_checker.sv
tb/testbench.sv
